### sv/atapio_pkg.sv
// Shared types, codes and result builders for the ATA PIO sector sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package atapio_pkg;

  localparam int MAX_RES = 6;

  localparam logic [31:0] LBA28_MAX   = 32'h0FFF_FFFF;
  localparam logic [7:0]  SR_BSY_BIT  = 8'h80;
  localparam logic [7:0]  SR_DF_BIT   = 8'h20;
  localparam logic [7:0]  SR_DRQ_BIT  = 8'h08;
  localparam logic [7:0]  SR_ERR_BIT  = 8'h01;
  localparam logic [7:0]  CMD_READ    = 8'h20;
  localparam logic [7:0]  CMD_WRITE   = 8'h30;
  localparam logic [7:0]  CMD_FLUSH   = 8'hE7;
  localparam logic [7:0]  DEVSEL_LBA  = 8'hE0;

  localparam logic [15:0] IO_BASE_RST    = 16'h01F0;
  localparam logic [15:0] CTL_PORT_RST   = 16'h03F6;
  localparam logic [23:0] POLL_LIMIT_RST = 24'd1000000;

  // task file register offsets
  localparam logic [2:0] TF_DATA   = 3'd0;
  localparam logic [2:0] TF_COUNT  = 3'd2;
  localparam logic [2:0] TF_LBA_LO = 3'd3;
  localparam logic [2:0] TF_LBA_MD = 3'd4;
  localparam logic [2:0] TF_LBA_HI = 3'd5;
  localparam logic [2:0] TF_DEVSEL = 3'd6;
  localparam logic [2:0] TF_CMDSTS = 3'd7;

  typedef enum logic [1:0] {
    ACT_START_RD = 2'd0,
    ACT_START_WR = 2'd1,
    ACT_RESP     = 2'd2,
    ACT_HWORD    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_WR    = 2'd0,
    KIND_RDREQ = 2'd1,
    KIND_HOST  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_BSY_TMO   = 3'd2,
    ST_DRQ_FAIL  = 3'd3,
    ST_FLUSH_TMO = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_IO_BASE    = 2'd0,
    CFG_CTL_PORT   = 2'd1,
    CFG_POLL_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WAIT_BSY,
    PH_SETTLE,
    PH_WAIT_DRQ,
    PH_DATA_IN,
    PH_DATA_OUT,
    PH_FLUSH
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_addr;
    logic [15:0] word_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port_addr;
    logic        wide;
    logic [15:0] word_out;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] io_base;
    logic [15:0] ctl_port;
    logic [23:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_write;
    logic [27:0] sector_addr;
    logic [23:0] poll_count;
    logic [1:0]  settle_count;
    logic [8:0]  word_count;
  } eng_state_t;

  typedef struct packed {
    eng_state_t                   nxt;
    logic [2:0]                   n;
    out_item_t [MAX_RES-1:0]      res;
  } step_out_t;

  function automatic logic [15:0] tf_port(input logic [15:0] base, input logic [2:0] off);
    return base + {13'd0, off};
  endfunction

  function automatic out_item_t mk_rd(input logic [15:0] port, input logic wide);
    out_item_t r;
    r = '0;
    r.kind      = KIND_RDREQ;
    r.port_addr = port;
    r.wide      = wide;
    return r;
  endfunction

  function automatic out_item_t mk_wr(input logic [15:0] port, input logic wide,
                                      input logic [15:0] word);
    out_item_t r;
    r = '0;
    r.kind      = KIND_WR;
    r.port_addr = port;
    r.wide      = wide;
    r.word_out  = word;
    return r;
  endfunction

  function automatic out_item_t mk_host(input logic [15:0] word);
    out_item_t r;
    r = '0;
    r.kind     = KIND_HOST;
    r.word_out = word;
    return r;
  endfunction

  function automatic out_item_t mk_done(input status_t st);
    out_item_t r;
    r = '0;
    r.kind   = KIND_DONE;
    r.status = st;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/atapio_step.sv
// Next-state and result-list logic for one transaction of the sequencer.
// Depends on atapio_pkg.
`default_nettype none

module atapio_step #(
  parameter int WORDS_PER_SECTOR = 256,
  parameter int SETTLE_READS     = 4
) (
  input  atapio_pkg::eng_state_t st,
  input  atapio_pkg::cfg_t       cfg,
  input  atapio_pkg::in_item_t   item,
  output atapio_pkg::step_out_t  so
);
  import atapio_pkg::*;

  logic [7:0]  sr;
  logic [23:0] poll_inc;
  logic        poll_out;
  logic [2:0]  settle_inc;
  logic [8:0]  wc_inc;
  logic        wc_full;
  logic        is_resp;

  assign sr         = item.word_in[7:0];
  assign poll_inc   = st.poll_count + 24'd1;
  assign poll_out   = poll_inc >= cfg.poll_limit;
  assign settle_inc = {1'b0, st.settle_count} + 3'd1;
  assign wc_inc     = st.word_count + 9'd1;
  assign wc_full    = wc_inc >= 9'(WORDS_PER_SECTOR);
  assign is_resp    = item.action == ACT_RESP;

  always_comb begin
    so     = '0;
    so.nxt = st;
    case (st.phase)
      PH_IDLE: begin
        if (item.action == ACT_START_RD || item.action == ACT_START_WR) begin
          if (item.block_addr > LBA28_MAX) begin
            so.res[0] = mk_done(ST_RANGE);
            so.n      = 3'd1;
          end else begin
            so.nxt.is_write    = item.action[0];
            so.nxt.sector_addr = item.block_addr[27:0];
            so.nxt.poll_count  = '0;
            so.nxt.phase       = PH_WAIT_BSY;
            so.res[0]          = mk_rd(tf_port(cfg.io_base, TF_CMDSTS), 1'b0);
            so.n               = 3'd1;
          end
        end
      end
      PH_WAIT_BSY: begin
        if (is_resp) begin
          if ((sr & SR_BSY_BIT) == 8'h00) begin
            so.res[0] = mk_wr(tf_port(cfg.io_base, TF_DEVSEL), 1'b0,
                              {8'h00, DEVSEL_LBA | {4'h0, st.sector_addr[27:24]}});
            so.res[1] = mk_rd(cfg.ctl_port, 1'b0);
            so.n      = 3'd2;
            so.nxt.settle_count = '0;
            so.nxt.phase        = PH_SETTLE;
          end else begin
            so.nxt.poll_count = poll_inc;
            so.n              = 3'd1;
            if (poll_out) begin
              so.res[0]    = mk_done(ST_BSY_TMO);
              so.nxt.phase = PH_IDLE;
            end else begin
              so.res[0] = mk_rd(tf_port(cfg.io_base, TF_CMDSTS), 1'b0);
            end
          end
        end
      end
      PH_SETTLE: begin
        if (is_resp) begin
          if (settle_inc < 3'(SETTLE_READS)) begin
            so.nxt.settle_count = settle_inc[1:0];
            so.res[0]           = mk_rd(cfg.ctl_port, 1'b0);
            so.n                = 3'd1;
          end else begin
            so.res[0] = mk_wr(tf_port(cfg.io_base, TF_COUNT), 1'b0, 16'd1);
            so.res[1] = mk_wr(tf_port(cfg.io_base, TF_LBA_LO), 1'b0,
                              {8'h00, st.sector_addr[7:0]});
            so.res[2] = mk_wr(tf_port(cfg.io_base, TF_LBA_MD), 1'b0,
                              {8'h00, st.sector_addr[15:8]});
            so.res[3] = mk_wr(tf_port(cfg.io_base, TF_LBA_HI), 1'b0,
                              {8'h00, st.sector_addr[23:16]});
            so.res[4] = mk_wr(tf_port(cfg.io_base, TF_CMDSTS), 1'b0,
                              {8'h00, st.is_write ? CMD_WRITE : CMD_READ});
            so.res[5] = mk_rd(tf_port(cfg.io_base, TF_CMDSTS), 1'b0);
            so.n      = 3'd6;
            so.nxt.poll_count = '0;
            so.nxt.phase      = PH_WAIT_DRQ;
          end
        end
      end
      PH_WAIT_DRQ: begin
        if (is_resp) begin
          if ((sr & (SR_ERR_BIT | SR_DF_BIT)) != 8'h00) begin
            so.res[0]    = mk_done(ST_DRQ_FAIL);
            so.n         = 3'd1;
            so.nxt.phase = PH_IDLE;
          end else if ((sr & SR_BSY_BIT) == 8'h00 && (sr & SR_DRQ_BIT) != 8'h00) begin
            so.nxt.word_count = '0;
            if (st.is_write) begin
              so.nxt.phase = PH_DATA_OUT;
            end else begin
              so.nxt.phase = PH_DATA_IN;
              so.res[0]    = mk_rd(tf_port(cfg.io_base, TF_DATA), 1'b1);
              so.n         = 3'd1;
            end
          end else begin
            so.nxt.poll_count = poll_inc;
            so.n              = 3'd1;
            if (poll_out) begin
              so.res[0]    = mk_done(ST_DRQ_FAIL);
              so.nxt.phase = PH_IDLE;
            end else begin
              so.res[0] = mk_rd(tf_port(cfg.io_base, TF_CMDSTS), 1'b0);
            end
          end
        end
      end
      PH_DATA_IN: begin
        if (is_resp) begin
          so.res[0]         = mk_host(item.word_in);
          so.n              = 3'd2;
          so.nxt.word_count = wc_inc;
          if (wc_full) begin
            so.res[1]    = mk_done(ST_OK);
            so.nxt.phase = PH_IDLE;
          end else begin
            so.res[1] = mk_rd(tf_port(cfg.io_base, TF_DATA), 1'b1);
          end
        end
      end
      PH_DATA_OUT: begin
        if (item.action == ACT_HWORD) begin
          so.res[0]         = mk_wr(tf_port(cfg.io_base, TF_DATA), 1'b1, item.word_in);
          so.n              = 3'd1;
          so.nxt.word_count = wc_inc;
          if (wc_full) begin
            so.res[1] = mk_wr(tf_port(cfg.io_base, TF_CMDSTS), 1'b0, {8'h00, CMD_FLUSH});
            so.res[2] = mk_rd(tf_port(cfg.io_base, TF_CMDSTS), 1'b0);
            so.n      = 3'd3;
            so.nxt.poll_count = '0;
            so.nxt.phase      = PH_FLUSH;
          end
        end
      end
      PH_FLUSH: begin
        if (is_resp) begin
          so.n = 3'd1;
          if ((sr & SR_BSY_BIT) == 8'h00) begin
            so.res[0]    = mk_done(ST_OK);
            so.nxt.phase = PH_IDLE;
          end else begin
            so.nxt.poll_count = poll_inc;
            if (poll_out) begin
              so.res[0]    = mk_done(ST_FLUSH_TMO);
              so.nxt.phase = PH_IDLE;
            end else begin
              so.res[0] = mk_rd(tf_port(cfg.io_base, TF_CMDSTS), 1'b0);
            end
          end
        end
      end
      default: begin
        so.nxt.phase = PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/atapio_serializer.sv
// Result buffer and output register: sends a transaction's results, one per
// cycle while the output is not stalled. Depends on atapio_pkg.
`default_nettype none

module atapio_serializer (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         load,
  input  wire [2:0]                                   load_n,
  input  atapio_pkg::out_item_t [atapio_pkg::MAX_RES-1:0] load_res,
  output logic                                        free,
  output logic                                        out_valid,
  input  wire                                         out_stall,
  output atapio_pkg::out_item_t                       out_data
);
  import atapio_pkg::*;

  out_item_t [MAX_RES-1:0] buf_res;
  logic [2:0]              n;
  logic [2:0]              idx;
  logic                    busy;
  logic                    out_load;
  logic                    last_now;
  out_item_t               cur;

  assign out_load = busy && (!out_valid || !out_stall);
  assign last_now = idx == (n - 3'd1);
  assign free     = !busy || (out_load && last_now);

  always_comb begin
    cur      = buf_res[idx];
    cur.last = last_now;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_res <= load_res;
      n       <= load_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_load) begin
      if (last_now) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= cur;
    end
  end

  // a loaded list is never empty and the read index stays inside it
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (n != 3'd0 && idx < n))
    else $error("serializer holds an empty or overrun result list");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && idx == 3'd0))
    else $error("new result list did not start at its first entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result list loaded over one still being sent");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_now && !load) |=> !busy)
    else $error("buffer still busy after its last result left");

endmodule

`default_nettype wire

### sv/ata_pio_sector_sequencer.sv
// Top level of the ATA PIO single-sector sequencer: input register, engine state,
// configuration registers. Depends on atapio_pkg, atapio_step, atapio_serializer.
`default_nettype none

// Host-side ATA PIO engine for one LBA28 sector. Start a transfer with a start item
// (read or write, block address), answer every bus read request (kind 1) with an
// action-2 item carrying the value read, and feed write data as action-3 items; the
// engine reports the end with a command-done result. Items the current phase does not
// expect are dropped without results. An accepted item is registered, evaluated
// combinationally, and its results (one to six) leave the output register one per
// cycle while the output is not stalled, the last one flagged. Throughput is set by
// that result serializer: single-result traffic runs at one item per cycle while the
// output is not stalled. Registers may be written at any time via the cfg port but
// take effect cleanly only while idle.
module ata_pio_sector_sequencer #(
  parameter int WORDS_PER_SECTOR = 256,
  parameter int SETTLE_READS     = 4
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  atapio_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output atapio_pkg::out_item_t  out_data,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [1:0]              cfg_index,
  input  wire [23:0]             cfg_data
);
  import atapio_pkg::*;

  in_item_t   in_q;
  logic       in_q_valid;
  eng_state_t st;
  cfg_t       cfg;
  step_out_t  so;
  logic       ser_free;
  logic       take;
  logic       in_accept;

  assign cfg_ready = 1'b1;
  assign take      = in_q_valid && ser_free;
  assign in_stall  = in_q_valid && !ser_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.io_base    <= IO_BASE_RST;
      cfg.ctl_port   <= CTL_PORT_RST;
      cfg.poll_limit <= POLL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IO_BASE:    cfg.io_base    <= cfg_data[15:0];
        CFG_CTL_PORT:   cfg.ctl_port   <= cfg_data[15:0];
        CFG_POLL_LIMIT: cfg.poll_limit <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (take) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, default: '0};
    end else if (take) begin
      st <= so.nxt;
    end
  end

  atapio_step #(
    .WORDS_PER_SECTOR (WORDS_PER_SECTOR),
    .SETTLE_READS     (SETTLE_READS)
  ) u_step (
    .st   (st),
    .cfg  (cfg),
    .item (in_q),
    .so   (so)
  );

  atapio_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (take && so.n != 3'd0),
    .load_n    (so.n),
    .load_res  (so.res),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
